### rtl/hes_pkg.sv
package hes_pkg;

   localparam int DATA_W     = 48;
   localparam int UVAL_W     = 47;
   localparam int FRAC_W     = 25;
   localparam int CSR_IDX_W  = 4;
   localparam int DEF_FRAC_BITS    = 24;
   localparam int DEF_REFLECT_MODE = 0;

   localparam logic [CSR_IDX_W-1:0] REG_SPOT_INIT  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VAR_INIT   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STRIKE     = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DISCOUNT   = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DRIFT      = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_REVERSION  = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_VAR   = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_VOL_OF_VAR = 4'd7;

   localparam logic [UVAL_W-1:0] RST_SPOT_INIT = 47'd1677721600;
   localparam logic [UVAL_W-1:0] RST_VAR_INIT  = 47'd671088;
   localparam logic [UVAL_W-1:0] RST_STRIKE    = 47'd1677721600;
   localparam logic [FRAC_W-1:0] RST_DISCOUNT  = 25'd16777216;
   localparam logic [UVAL_W-1:0] RST_LONG_VAR  = 47'd671088;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PREP, ST_ROOT, ST_ISSUE, ST_MULW, ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      OP_SQDW1, OP_REV, OP_VOLSQ, OP_SHOCK, OP_SPOT, OP_CALL, OP_PUT
   } op_type;

   typedef struct packed {
      logic                     start;
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
   } mul_req_type;

   function automatic logic signed [DATA_W-1:0] sat48(input logic signed [DATA_W+1:0] v);
      logic signed [DATA_W+1:0] hi;
      logic signed [DATA_W+1:0] lo;
      hi = {3'b000, {(DATA_W-1){1'b1}}};
      lo = {3'b111, {(DATA_W-1){1'b0}}};
      if (v > hi) begin
         return hi[DATA_W-1:0];
      end else if (v < lo) begin
         return lo[DATA_W-1:0];
      end
      return v[DATA_W-1:0];
   endfunction

endpackage

### rtl/hes_mul.sv
module hes_mul
   import hes_pkg::*;
#(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mul_req_type              req,
   output logic                     done,
   output logic signed [DATA_W-1:0] result
);

   localparam int HALF_W = DATA_W / 2;
   localparam int ACC_W  = 2 * DATA_W;

   logic [DATA_W-1:0]        ua_ff, ua_in, ub_ff, ub_in;
   logic                     neg_ff, neg_in;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic [1:0]               cnt_ff, cnt_in;
   logic                     busy_ff, busy_in, fin_ff, fin_in, done_ff, done_in;
   logic signed [DATA_W-1:0] res_ff, res_in;
   logic [HALF_W-1:0]        pa, pb;
   logic [DATA_W-1:0]        pp;
   logic [ACC_W-1:0]         pp_sh, shifted;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      ua_ff  <= ua_in;
      ub_ff  <= ub_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
   end

   always_comb begin
      pa = cnt_ff[0] ? ua_ff[DATA_W-1:HALF_W] : ua_ff[HALF_W-1:0];
      pb = cnt_ff[1] ? ub_ff[DATA_W-1:HALF_W] : ub_ff[HALF_W-1:0];
      pp = DATA_W'(pa) * DATA_W'(pb);
      unique case (cnt_ff)
         2'd0:    pp_sh = ACC_W'(pp);
         2'd1,
         2'd2:    pp_sh = ACC_W'(pp) << HALF_W;
         default: pp_sh = ACC_W'(pp) << DATA_W;
      endcase
      shifted = acc_ff >> FRAC_BITS;

      ua_in   = ua_ff;
      ub_in   = ub_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      res_in  = res_ff;

      if (req.start) begin
         ua_in   = req.a[DATA_W-1] ? DATA_W'(-req.a) : req.a;
         ub_in   = req.b[DATA_W-1] ? DATA_W'(-req.b) : req.b;
         neg_in  = req.a[DATA_W-1] ^ req.b[DATA_W-1];
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + pp_sh;
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end

      if (fin_ff) begin
         done_in = 1'b1;
         if (neg_ff) begin
            if (shifted[ACC_W-1:DATA_W] != '0 ||
                shifted[DATA_W-1:0] > {1'b1, {(DATA_W-1){1'b0}}}) begin
               res_in = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
               res_in = -$signed(shifted[DATA_W-1:0]);
            end
         end else begin
            if (shifted[ACC_W-1:DATA_W-1] != '0) begin
               res_in = {1'b0, {(DATA_W-1){1'b1}}};
            end else begin
               res_in = $signed(shifted[DATA_W-1:0]);
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

### rtl/hes_root.sv
module hes_root
   import hes_pkg::*;
#(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [UVAL_W-1:0]        value,
   output logic                     done,
   output logic signed [DATA_W-1:0] root
);

   localparam int STEPS = (UVAL_W + FRAC_BITS + 1) / 2;
   localparam int RAD_W = 2 * STEPS;
   localparam int REM_W = STEPS + 2;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic [RAD_W-1:0] rad_ff, rad_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [STEPS-1:0] root_ff, root_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [REM_W+1:0] remx, trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   always_comb begin
      remx    = {rem_ff, rad_ff[RAD_W-1:RAD_W-2]};
      trial   = (REM_W+2)'({root_ff, 2'b01});
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = RAD_W'({value, {FRAC_BITS{1'b0}}});
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = rad_ff << 2;
         if (remx >= trial) begin
            rem_in  = REM_W'(remx - trial);
            root_in = {root_ff[STEPS-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(remx);
            root_in = {root_ff[STEPS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign root = $signed(DATA_W'(root_ff));

endmodule

### rtl/heston_euler_path_step.sv
// channel  direction  handshake             payload
// req_     in         req_valid/req_stall   spot_noise, var_noise, last_step
// rsp_     out        rsp_valid/rsp_stall   call_payoff, put_payoff, terminal_spot
// csr_     in         csr_valid/csr_ready   csr_index, csr_data
// One step runs accept, root start and square root, then 5 multiplies (7 and an emit
// on a last step). Root and 24x24 partial-product multiplier are shared, sequential.
// req_stall is high from acceptance until the step is done.
// A result waits in the output register; a last step ends only once it is free.
// Reset (synchronous) restores register defaults and starts a fresh path.
module heston_euler_path_step
   import hes_pkg::*;
#(
   parameter int REFLECT_MODE = DEF_REFLECT_MODE,
   parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_spot_noise,
   input  logic signed [DATA_W-1:0] req_var_noise,
   input  logic                     req_last_step,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [UVAL_W-1:0]        rsp_call_payoff,
   output logic [UVAL_W-1:0]        rsp_put_payoff,
   output logic signed [DATA_W-1:0] rsp_terminal_spot,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_data
);

   localparam logic signed [DATA_W+1:0] ONE_Q = (DATA_W+2)'(1) << FRAC_BITS;

   logic [UVAL_W-1:0]        spot_init_ff, var_init_ff, strike_ff, long_var_ff, vol_ff;
   logic [FRAC_W-1:0]        disc_ff, revsp_ff;
   logic signed [DATA_W-1:0] drift_ff;

   state_type                state_ff, state_in;
   op_type                   op_ff, op_in;
   logic                     fresh_ff, fresh_in, last_ff, last_in;
   logic signed [DATA_W-1:0] spot_ff, spot_in, var_ff, var_in;
   logic signed [DATA_W-1:0] dw1_ff, dw1_in, dw2_ff, dw2_in;
   logic signed [DATA_W-1:0] t1_ff, t1_in, t2_ff, t2_in, t3_ff, t3_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [UVAL_W-1:0]        call_ff, call_in, put_ff, put_in;
   logic signed [DATA_W-1:0] term_ff, term_in;

   mul_req_type              mreq;
   logic                     mul_done, root_start, root_done;
   logic signed [DATA_W-1:0] mul_res, sq;
   logic [UVAL_W-1:0]        tv;
   logic signed [DATA_W-1:0] factor, rdiff, cdiff, pdiff;

   hes_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .req    (mreq),
      .done   (mul_done),
      .result (mul_res)
   );

   hes_root #(.FRAC_BITS(FRAC_BITS)) u_root (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .value (tv),
      .done  (root_done),
      .root  (sq)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         spot_init_ff <= RST_SPOT_INIT;
         var_init_ff  <= RST_VAR_INIT;
         strike_ff    <= RST_STRIKE;
         disc_ff      <= RST_DISCOUNT;
         drift_ff     <= '0;
         revsp_ff     <= '0;
         long_var_ff  <= RST_LONG_VAR;
         vol_ff       <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_SPOT_INIT:  spot_init_ff <= csr_data[UVAL_W-1:0];
            REG_VAR_INIT:   var_init_ff  <= csr_data[UVAL_W-1:0];
            REG_STRIKE:     strike_ff    <= csr_data[UVAL_W-1:0];
            REG_DISCOUNT:   disc_ff      <= csr_data[FRAC_W-1:0];
            REG_DRIFT:      drift_ff     <= $signed(csr_data);
            REG_REVERSION:  revsp_ff     <= csr_data[FRAC_W-1:0];
            REG_LONG_VAR:   long_var_ff  <= csr_data[UVAL_W-1:0];
            REG_VOL_OF_VAR: vol_ff       <= csr_data[UVAL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fresh_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         spot_ff      <= '0;
         var_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
         spot_ff      <= spot_in;
         var_ff       <= var_in;
      end
      op_ff   <= op_in;
      last_ff <= last_in;
      dw1_ff  <= dw1_in;
      dw2_ff  <= dw2_in;
      t1_ff   <= t1_in;
      t2_ff   <= t2_in;
      t3_ff   <= t3_in;
      call_ff <= call_in;
      put_ff  <= put_in;
      term_ff <= term_in;
   end

   always_comb begin
      if (var_ff[DATA_W-1]) begin
         if (REFLECT_MODE != 0) begin
            tv = (var_ff == {1'b1, {(DATA_W-1){1'b0}}}) ? {UVAL_W{1'b1}}
                                                         : UVAL_W'(-var_ff);
         end else begin
            tv = '0;
         end
      end else begin
         tv = var_ff[UVAL_W-1:0];
      end
      factor = sat48(ONE_Q + (DATA_W+2)'(drift_ff) + (DATA_W+2)'(t1_ff));
      rdiff  = sat48($signed({3'b000, long_var_ff}) - (DATA_W+2)'(var_ff));
      cdiff  = sat48((DATA_W+2)'(spot_ff) - $signed({3'b000, strike_ff}));
      pdiff  = sat48($signed({3'b000, strike_ff}) - (DATA_W+2)'(spot_ff));

      mreq.start = (state_ff == ST_ISSUE);
      unique case (op_ff)
         OP_SQDW1: begin mreq.a = sq; mreq.b = dw1_ff; end
         OP_REV: begin mreq.a = $signed(DATA_W'(revsp_ff)); mreq.b = rdiff; end
         OP_VOLSQ: begin mreq.a = $signed(DATA_W'(vol_ff)); mreq.b = sq; end
         OP_SHOCK: begin mreq.a = t3_ff; mreq.b = dw2_ff; end
         OP_SPOT: begin mreq.a = spot_ff; mreq.b = factor; end
         OP_CALL: begin
            mreq.a = $signed(DATA_W'(disc_ff));
            mreq.b = (cdiff > 0) ? cdiff : '0;
         end
         default: begin
            mreq.a = $signed(DATA_W'(disc_ff));
            mreq.b = (pdiff > 0) ? pdiff : '0;
         end
      endcase

      root_start   = (state_ff == ST_PREP);
      req_stall    = (state_ff != ST_IDLE);
      state_in     = state_ff;
      op_in        = op_ff;
      fresh_in     = fresh_ff;
      last_in      = last_ff;
      spot_in      = spot_ff;
      var_in       = var_ff;
      dw1_in       = dw1_ff;
      dw2_in       = dw2_ff;
      t1_in        = t1_ff;
      t2_in        = t2_ff;
      t3_in        = t3_ff;
      call_in      = call_ff;
      put_in       = put_ff;
      term_in      = term_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dw1_in  = req_spot_noise;
               dw2_in  = req_var_noise;
               last_in = req_last_step;
               if (fresh_ff) begin
                  spot_in  = $signed(DATA_W'(spot_init_ff));
                  var_in   = $signed(DATA_W'(var_init_ff));
                  fresh_in = 1'b0;
               end
               state_in = ST_PREP;
            end
         end
         ST_PREP: state_in = ST_ROOT;
         ST_ROOT: begin
            if (root_done) begin
               op_in    = OP_SQDW1;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: state_in = ST_MULW;
         ST_MULW: begin
            if (mul_done) begin
               state_in = ST_ISSUE;
               unique case (op_ff)
                  OP_SQDW1: begin t1_in = mul_res; op_in = OP_REV; end
                  OP_REV: begin t2_in = mul_res; op_in = OP_VOLSQ; end
                  OP_VOLSQ: begin t3_in = mul_res; op_in = OP_SHOCK; end
                  OP_SHOCK: begin t3_in = mul_res; op_in = OP_SPOT; end
                  OP_SPOT: begin
                     spot_in = mul_res;
                     var_in  = sat48((DATA_W+2)'(var_ff) + (DATA_W+2)'(t2_ff)
                                     + (DATA_W+2)'(t3_ff));
                     op_in   = OP_CALL;
                     if (!last_ff) begin
                        state_in = ST_IDLE;
                     end
                  end
                  OP_CALL: begin t1_in = mul_res; op_in = OP_PUT; end
                  default: begin t2_in = mul_res; state_in = ST_EMIT; end
               endcase
            end
         end
         default: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               call_in      = t1_ff[UVAL_W-1:0];
               put_in       = t2_ff[UVAL_W-1:0];
               term_in      = spot_ff;
               rsp_valid_in = 1'b1;
               fresh_in     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_call_payoff   = call_ff;
   assign rsp_put_payoff    = put_ff;
   assign rsp_terminal_spot = term_ff;

endmodule

### verif/heston_step_checker.sv
module heston_step_checker
   import hes_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_spot_noise,
   input  logic signed [DATA_W-1:0] req_var_noise,
   input  logic                     req_last_step,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [UVAL_W-1:0]        rsp_call_payoff,
   input  logic [UVAL_W-1:0]        rsp_put_payoff,
   input  logic signed [DATA_W-1:0] rsp_terminal_spot,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_data,
   output int                       fail_count,
   output int                       payoffs_pending,
   output int                       payoffs_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FB = DEF_FRAC_BITS;
   localparam logic signed [63:0] MAXV = 64'sh7FFF_FFFF_FFFF;
   localparam logic signed [63:0] MINV = -64'sh8000_0000_0000;

   typedef struct packed {
      logic [UVAL_W-1:0]        call_payoff;
      logic [UVAL_W-1:0]        put_payoff;
      logic signed [DATA_W-1:0] terminal_spot;
   } payoff_type;

   payoff_type payoff_q[$];

   logic [UVAL_W-1:0]        m_spot_init, m_var_init, m_strike, m_long_var, m_vol;
   logic [FRAC_W-1:0]        m_disc, m_rev;
   logic signed [DATA_W-1:0] m_drift;
   logic signed [63:0]       spot_now, var_now;
   logic                     fresh;

   function automatic logic signed [63:0] clip(input logic signed [127:0] v);
      if (v > MAXV) return MAXV;
      if (v < MINV) return MINV;
      return v[63:0];
   endfunction

   function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
      logic signed [127:0] p;
      logic                neg;
      p = 128'(a) * 128'(b);
      neg = p < 0;
      if (neg) p = -p;
      p = p >>> FB;
      if (neg) p = -p;
      return clip(p);
   endfunction

   function automatic logic signed [63:0] qroot(input logic signed [63:0] x);
      logic [127:0] v;
      logic [127:0] r;
      logic [127:0] c;
      v = 128'(x) << FB;
      r = 0;
      for (int b = 47; b >= 0; b--) begin
         c = r | (128'd1 << b);
         if (c * c <= v) r = c;
      end
      return r[63:0];
   endfunction

   function automatic logic [UVAL_W-1:0] clamp_u(input logic signed [63:0] v);
      if (v < 0) return '0;
      if (v > 64'sh7FFF_FFFF_FFFF) return {UVAL_W{1'b1}};
      return v[UVAL_W-1:0];
   endfunction

   task automatic advance_path(input logic signed [63:0] dw1, input logic signed [63:0] dw2,
                               input logic last);
      logic signed [63:0] tv, sq, factor, dif, rev, shock, disc;
      payoff_type         p;
      if (fresh) begin
         spot_now = 64'(m_spot_init);
         var_now = 64'(m_var_init);
         fresh = 0;
      end
      if (DEF_REFLECT_MODE != 0) tv = var_now < 0 ? clip(-128'(var_now)) : var_now;
      else tv = var_now < 0 ? 64'sd0 : var_now;
      sq = qroot(tv);
      factor = clip(128'(64'sd1 <<< FB) + 128'(64'(m_drift)) + 128'(qmul(sq, dw1)));
      dif = clip(128'(64'(m_long_var)) - 128'(var_now));
      rev = qmul(64'(m_rev), dif);
      shock = qmul(qmul(64'(m_vol), sq), dw2);
      spot_now = qmul(spot_now, factor);
      var_now = clip(128'(var_now) + 128'(rev) + 128'(shock));
      if (last) begin
         disc = 64'(m_disc);
         dif = clip(128'(spot_now) - 128'(64'(m_strike)));
         p.call_payoff = clamp_u(dif > 0 ? qmul(disc, dif) : 64'sd0);
         dif = clip(128'(64'(m_strike)) - 128'(spot_now));
         p.put_payoff = clamp_u(dif > 0 ? qmul(disc, dif) : 64'sd0);
         p.terminal_spot = spot_now[DATA_W-1:0];
         payoff_q.push_back(p);
         fresh = 1;
      end
   endtask

   assign payoffs_pending = payoff_q.size();

   always @(posedge clock) begin
      payoff_type e;
      if (reset) begin
         m_spot_init <= RST_SPOT_INIT;
         m_var_init <= RST_VAR_INIT;
         m_strike <= RST_STRIKE;
         m_disc <= RST_DISCOUNT;
         m_drift <= '0;
         m_rev <= '0;
         m_long_var <= RST_LONG_VAR;
         m_vol <= '0;
         spot_now = 0;
         var_now = 0;
         fresh = 1;
         payoff_q.delete();
         fail_count <= 0;
         payoffs_seen <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_SPOT_INIT:  m_spot_init <= csr_data[UVAL_W-1:0];
               REG_VAR_INIT:   m_var_init <= csr_data[UVAL_W-1:0];
               REG_STRIKE:     m_strike <= csr_data[UVAL_W-1:0];
               REG_DISCOUNT:   m_disc <= csr_data[FRAC_W-1:0];
               REG_DRIFT:      m_drift <= csr_data;
               REG_REVERSION:  m_rev <= csr_data[FRAC_W-1:0];
               REG_LONG_VAR:   m_long_var <= csr_data[UVAL_W-1:0];
               REG_VOL_OF_VAR: m_vol <= csr_data[UVAL_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            advance_path(64'(req_spot_noise), 64'(req_var_noise), req_last_step);
         if (rsp_valid && !rsp_stall) begin
            payoffs_seen <= payoffs_seen + 1;
            if (payoff_q.size() == 0) begin
               $display("%0t: unexpected payoff transaction call=%0d put=%0d spot=%0d",
                        $time, rsp_call_payoff, rsp_put_payoff, rsp_terminal_spot);
               fail_count <= fail_count + 1;
            end else begin
               e = payoff_q.pop_front();
               if (e.call_payoff !== rsp_call_payoff || e.put_payoff !== rsp_put_payoff ||
                   e.terminal_spot !== rsp_terminal_spot) begin
                  $display("%0t: payoff mismatch expected call=%0d put=%0d spot=%0d",
                           $time, e.call_payoff, e.put_payoff, e.terminal_spot);
                  $display("%0t:                 actual   call=%0d put=%0d spot=%0d",
                           $time, rsp_call_payoff, rsp_put_payoff, rsp_terminal_spot);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

### verif/tb_heston_euler_path_step.sv
module tb_heston_euler_path_step;
   timeunit 1ns;
   timeprecision 1ps;
   import hes_pkg::*;

   localparam int IDLE_LIMIT = 20000;
   localparam logic [DATA_W-1:0] ONE_Q = 48'd16777216;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 4'd9;

   logic                     clock = 0;
   logic                     reset = 1;
   logic                     req_valid = 0;
   logic                     req_stall;
   logic signed [DATA_W-1:0] req_spot_noise = '0;
   logic signed [DATA_W-1:0] req_var_noise = '0;
   logic                     req_last_step = 0;
   logic                     rsp_valid;
   logic                     rsp_stall = 0;
   logic [UVAL_W-1:0]        rsp_call_payoff;
   logic [UVAL_W-1:0]        rsp_put_payoff;
   logic signed [DATA_W-1:0] rsp_terminal_spot;
   logic                     csr_valid = 0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [DATA_W-1:0]        csr_data = '0;
   int                       fail_count, payoffs_pending, payoffs_seen;
   int                       send_idle_pct = 0, stall_pct = 0;
   int                       quiet_cycles = 0, steps_sent = 0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   heston_euler_path_step u_top (.*);

   heston_step_checker u_chk (.*);

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > IDLE_LIMIT) begin
         $display("%0t: watchdog expired, no transaction for %0d cycles", $time, IDLE_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
   endtask

   // valid stays high after acceptance; an idle cycle of the next call or drain drops it
   task automatic send_step(input logic [DATA_W-1:0] dw1, input logic [DATA_W-1:0] dw2,
                            input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_spot_noise <= dw1;
      req_var_noise <= dw2;
      req_last_step <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      steps_sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (payoffs_pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] small_noise();
      return 48'($signed($urandom_range(2 * 800000)) - 800000);
   endfunction

   function automatic logic [DATA_W-1:0] any_pos();
      return 48'({$urandom, $urandom}) & 48'h7FFF_FFFF_FFFF;
   endfunction

   function automatic logic [DATA_W-1:0] any_noise();
      case ($urandom_range(3))
         0: return 48'({$urandom, $urandom});
         1: return $urandom_range(1) ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
         default: return small_noise();
      endcase
   endfunction

   task automatic random_settings(input bit extreme);
      write_reg(REG_SPOT_INIT, extreme ? any_pos() : 48'($urandom_range(32'h7FFF_FFFF)));
      write_reg(REG_VAR_INIT, extreme ? any_pos() : 48'($urandom_range(4000000)));
      write_reg(REG_STRIKE, extreme ? any_pos() : 48'($urandom_range(32'h7FFF_FFFF)));
      write_reg(REG_DISCOUNT, 48'($urandom_range(16777216)));
      write_reg(REG_DRIFT, extreme ? 48'({$urandom, $urandom})
                                   : 48'($signed($urandom_range(20000)) - 10000));
      write_reg(REG_REVERSION, 48'($urandom_range(16777216)));
      write_reg(REG_LONG_VAR, extreme ? any_pos() : 48'($urandom_range(4000000)));
      write_reg(REG_VOL_OF_VAR, extreme ? any_pos() : 48'($urandom_range(16777216)));
   endtask

   initial begin
      int n;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // defaults, then extremes of the noise fields
      send_step('0, '0, 1);
      send_step(48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 0);
      send_step(48'h8000_0000_0000, 48'h8000_0000_0000, 1);
      send_step(48'hFFFF_FFFF_FFFF, 48'h0000_0000_0001, 1);
      drain();
      write_reg(REG_VOL_OF_VAR, ONE_Q);
      write_reg(REG_REVERSION, 48'd16777216);
      write_reg(REG_DRIFT, 48'h8000_0000_0000);
      write_reg(REG_UNUSED, 48'hFFFF_FFFF_FFFF);
      send_step(48'd100000, 48'h8000_0000_0000, 0);
      send_step(48'd100000, 48'd5000, 1);
      drain();
      write_reg(REG_DRIFT, 48'h7FFF_FFFF_FFFF);
      write_reg(REG_DISCOUNT, 48'h1FF_FFFF);
      write_reg(REG_SPOT_INIT, 48'h7FFF_FFFF_FFFF);
      write_reg(REG_VAR_INIT, 48'h7FFF_FFFF_FFFF);
      write_reg(REG_LONG_VAR, 48'h7FFF_FFFF_FFFF);
      write_reg(REG_STRIKE, '0);
      send_step(48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 1);
      send_step(48'h8000_0000_0000, 48'd1, 1);
      drain();
      write_reg(REG_STRIKE, 48'h7FFF_FFFF_FFFF);
      write_reg(REG_SPOT_INIT, '0);
      write_reg(REG_VAR_INIT, '0);
      write_reg(REG_LONG_VAR, '0);
      write_reg(REG_DISCOUNT, '0);
      send_step(48'h8000_0000_0000, 48'h8000_0000_0000, 1);
      drain();
      write_reg(REG_DRIFT, 48'hFFFF_FF00_0000);
      write_reg(REG_DISCOUNT, ONE_Q);
      write_reg(REG_SPOT_INIT, 48'd1677721600);
      send_step(48'd0, 48'd0, 1);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 48; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 48; end
            default: begin send_idle_pct = 7; stall_pct = 7; end
         endcase
         random_settings(phase == 3 || phase == 7);
         n = 0;
         while (n < 250) begin
            int len;
            len = $urandom_range(12, 1);
            for (int k = 0; k < len; k++) begin
               send_step($urandom_range(9) == 0 ? any_noise() : small_noise(),
                         $urandom_range(9) == 0 ? any_noise() : small_noise(),
                         k == len - 1 || $urandom_range(19) == 0);
               n++;
            end
            if (phase == 5 && n > 120 && n < 135) begin
               req_valid <= 0;
               while (payoffs_pending != 0) @(posedge clock);
            end
         end
         drain();
      end

      $display("Sent %0d path steps and checked %0d payoff transactions over corner settings",
               steps_sent, payoffs_seen);
      $display("and 8 random register sets, with idle and stall mixes from none to 48 percent.");
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
